// ===== rtl/bta_pkg.sv =====
`timescale 1ns / 1ps

package bta_pkg;

  // arena geometry
  localparam int MEM_BYTES = 4096;
  localparam int AW        = 12;
  localparam int SW        = 13;

  // tag sizes as adder constants
  localparam logic [3:0] K_ZERO = 4'd0;
  localparam logic [3:0] K_TAG  = 4'd6;
  localparam logic [3:0] K_PAIR = 4'd12;

  localparam logic [SW-1:0] ARENA_MIN = 13'd12;
  localparam logic [SW-1:0] ARENA_MAX = 13'd4096;

  // one boundary tag as held in the tag store
  typedef struct packed {
    logic          is_free;
    logic [AW-1:0] size;
    logic          no_link;
    logic [AW-1:0] link;
  } tag_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_W_HD, S_W_TD,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8, S_F9,
    S_DONE
  } state_e;

  // request to the shared adder: a + b + k, or a - b - k
  typedef struct packed {
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    logic [3:0]    k;
    logic          sub;
  } calc_req_t;

  // tag store port request
  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    tag_t          wr_data;
  } mem_req_t;

endpackage

// ===== rtl/bta_calc.sv =====
`timescale 1ns / 1ps

module bta_calc import bta_pkg::*; (
  input  calc_req_t     req_i,
  output logic [SW-1:0] sum_o
);

  // add or subtract operand and tag constant
  always_comb begin
    if (req_i.sub) begin
      sum_o = req_i.a - req_i.b - {{(SW-4){1'b0}}, req_i.k};
    end else begin
      sum_o = req_i.a + req_i.b + {{(SW-4){1'b0}}, req_i.k};
    end
  end

endmodule

// ===== rtl/bta_tag_ram.sv =====
`timescale 1ns / 1ps

module bta_tag_ram import bta_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output tag_t     rdata_o
);

  tag_t mem [MEM_BYTES];

  // write one tag
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_o <= mem[req_i.rd_addr];
    end
  end

endmodule

// ===== rtl/bta_seq.sv =====
`timescale 1ns / 1ps

module bta_seq import bta_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          arena_size_we_i,
  input  logic [SW-1:0] arena_size_i,
  input  logic [1:0]    opcode_i,
  input  logic [AW-1:0] request_size_i,
  input  logic [AW-1:0] block_address_i,
  output mem_req_t      mem_o,
  input  tag_t          rdata_i,
  output calc_req_t     calc_o,
  input  logic [SW-1:0] sum_i,
  output logic          done_o,
  output logic          status_o,
  output logic [AW-1:0] result_address_o,
  output logic [8:0]    live_count_o,
  output logic [AW-1:0] used_bytes_o,
  output logic [AW-1:0] largest_free_o
);

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  logic [SW-1:0] asize_q, asize_d;
  logic [AW-1:0] s_q, s_d, p_q, p_d;
  logic [AW-1:0] off_q, off_d, hsize_q, hsize_d, link_q, link_d;
  logic          nl_q, nl_d;
  logic [AW-1:0] end_q, end_d, endlink_q, endlink_d;
  logic          endnl_q, endnl_d;
  logic [AW-1:0] tsize_q, tsize_d, taddr_q, taddr_d, nxt_q, nxt_d;
  logic [AW-1:0] big_q, big_d, raddr_q, raddr_d;
  logic          ok_q, ok_d;
  logic [8:0]    count_q, count_d;
  logic [AW-1:0] used_q, used_d;
  logic          done_q, done_d, status_q, status_d;
  logic [AW-1:0] ra_q, ra_d, ub_q, ub_d, lf_q, lf_d;
  logic [8:0]    lc_q, lc_d;
  logic          fit, hit;
  logic [SW-1:0] asize_sat;

  // clamp the written arena size
  always_comb begin
    if (arena_size_i < ARENA_MIN) begin
      asize_sat = ARENA_MIN;
    end else if (arena_size_i > ARENA_MAX) begin
      asize_sat = ARENA_MAX;
    end else begin
      asize_sat = arena_size_i;
    end
  end

  // head tests during the walk
  assign fit = rdata_i.is_free &&
               ({1'b0, rdata_i.size} >= ({1'b0, s_q} + {{(SW-4){1'b0}}, K_PAIR}));
  assign hit = !rdata_i.is_free &&
               (({1'b0, off_q} + {{(SW-4){1'b0}}, K_TAG}) == {1'b0, p_q});

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT0;
      asize_q <= ARENA_MAX;
      count_q <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      asize_q <= asize_d;
      count_q <= count_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  // work and output words
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    s_q       <= s_d;
    p_q       <= p_d;
    off_q     <= off_d;
    hsize_q   <= hsize_d;
    link_q    <= link_d;
    nl_q      <= nl_d;
    end_q     <= end_d;
    endlink_q <= endlink_d;
    endnl_q   <= endnl_d;
    tsize_q   <= tsize_d;
    taddr_q   <= taddr_d;
    nxt_q     <= nxt_d;
    big_q     <= big_d;
    raddr_q   <= raddr_d;
    ok_q      <= ok_d;
    status_q  <= status_d;
    ra_q      <= ra_d;
    lc_q      <= lc_d;
    ub_q      <= ub_d;
    lf_q      <= lf_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    asize_d   = asize_q;
    s_d       = s_q;
    p_d       = p_q;
    off_d     = off_q;
    hsize_d   = hsize_q;
    link_d    = link_q;
    nl_d      = nl_q;
    end_d     = end_q;
    endlink_d = endlink_q;
    endnl_d   = endnl_q;
    tsize_d   = tsize_q;
    taddr_d   = taddr_q;
    nxt_d     = nxt_q;
    big_d     = big_q;
    raddr_d   = raddr_q;
    ok_d      = ok_q;
    count_d   = count_q;
    used_d    = used_q;
    done_d    = 1'b0;
    status_d  = status_q;
    ra_d      = ra_q;
    lc_d      = lc_q;
    ub_d      = ub_q;
    lf_d      = lf_q;
    mem_o     = '0;
    calc_o    = '0;

    case (state_q)
      S_INIT0: begin
        calc_o  = '{a: asize_q, b: '0, k: K_PAIR, sub: 1'b1};
        hsize_d = sum_i[AW-1:0];
        count_d = '0;
        used_d  = '0;
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = '0;
        mem_o.wr_data = '{is_free: 1'b1, size: sum_i[AW-1:0], no_link: 1'b1, link: '0};
        state_d = S_INIT1;
      end
      S_INIT1: begin
        calc_o  = '{a: asize_q, b: '0, k: K_TAG, sub: 1'b1};
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = sum_i[AW-1:0];
        mem_o.wr_data = '{is_free: 1'b1, size: hsize_q, no_link: 1'b1, link: '0};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start && !arena_size_we_i) begin
          op_d    = op_e'(opcode_i);
          s_d     = request_size_i;
          p_d     = block_address_i;
          off_d   = '0;
          big_d   = '0;
          ok_d    = 1'b0;
          raddr_d = '0;
          if (op_e'(opcode_i) == OP_NONE) begin
            state_d = S_DONE;
          end else begin
            mem_o.rd_en   = 1'b1;
            mem_o.rd_addr = '0;
            state_d = S_W_HD;
          end
        end
      end
      // head of the current block
      S_W_HD: begin
        hsize_d = rdata_i.size;
        nl_d    = rdata_i.no_link;
        link_d  = rdata_i.link;
        if (rdata_i.is_free && (rdata_i.size >= AW'(K_PAIR)) &&
            ((rdata_i.size - AW'(K_PAIR)) > big_q)) begin
          big_d = rdata_i.size - AW'(K_PAIR);
        end
        if (op_q == OP_ALLOC && fit) begin
          state_d = S_A0;
        end else if (op_q == OP_FREE && hit) begin
          state_d = S_F0;
        end else begin
          calc_o = '{a: {1'b0, off_q}, b: {1'b0, rdata_i.size}, k: K_TAG, sub: 1'b0};
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = sum_i[AW-1:0];
          state_d = S_W_TD;
        end
      end
      // tail: follow the link or stop
      S_W_TD: begin
        if (rdata_i.no_link) begin
          ok_d    = (op_q == OP_REPORT);
          state_d = S_DONE;
        end else begin
          off_d = rdata_i.link;
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = rdata_i.link;
          state_d = S_W_HD;
        end
      end
      S_A0: begin
        calc_o = '{a: {1'b0, off_q}, b: {1'b0, hsize_q}, k: K_TAG, sub: 1'b0};
        end_d  = sum_i[AW-1:0];
        mem_o.rd_en   = 1'b1;
        mem_o.rd_addr = sum_i[AW-1:0];
        state_d = S_A1;
      end
      S_A1: begin
        endnl_d   = rdata_i.no_link;
        endlink_d = rdata_i.link;
        calc_o  = '{a: {1'b0, hsize_q}, b: {1'b0, s_q}, k: K_PAIR, sub: 1'b1};
        tsize_d = sum_i[AW-1:0];
        state_d = S_A2;
      end
      S_A2: begin
        calc_o  = '{a: {1'b0, off_q}, b: {1'b0, tsize_q}, k: K_TAG, sub: 1'b0};
        taddr_d = sum_i[AW-1:0];
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = off_q;
        mem_o.wr_data = '{is_free: 1'b1, size: tsize_q, no_link: nl_q, link: link_q};
        state_d = S_A3;
      end
      S_A3: begin
        calc_o = '{a: {1'b0, taddr_q}, b: '0, k: K_TAG, sub: 1'b0};
        nxt_d  = sum_i[AW-1:0];
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = taddr_q;
        mem_o.wr_data = '{is_free: 1'b1, size: tsize_q, no_link: 1'b0,
                          link: sum_i[AW-1:0]};
        state_d = S_A4;
      end
      S_A4: begin
        calc_o  = '{a: {1'b0, nxt_q}, b: '0, k: K_TAG, sub: 1'b0};
        raddr_d = sum_i[AW-1:0];
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = nxt_q;
        mem_o.wr_data = '{is_free: 1'b0, size: s_q, no_link: 1'b0, link: taddr_q};
        state_d = S_A5;
      end
      S_A5: begin
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = end_q;
        mem_o.wr_data = '{is_free: 1'b0, size: s_q, no_link: endnl_q, link: endlink_q};
        count_d = count_q + 9'd1;
        used_d  = used_q + s_q;
        ok_d    = 1'b1;
        state_d = S_DONE;
      end
      S_F0: begin
        calc_o = '{a: {1'b0, off_q}, b: {1'b0, hsize_q}, k: K_TAG, sub: 1'b0};
        end_d  = sum_i[AW-1:0];
        mem_o.rd_en   = 1'b1;
        mem_o.rd_addr = sum_i[AW-1:0];
        state_d = S_F1;
      end
      // mark tail free and drop the counters
      S_F1: begin
        endnl_d   = rdata_i.no_link;
        endlink_d = rdata_i.link;
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = end_q;
        mem_o.wr_data = '{is_free: 1'b1, size: rdata_i.size, no_link: rdata_i.no_link,
                          link: rdata_i.link};
        count_d = count_q - 9'd1;
        used_d  = used_q - hsize_q;
        state_d = S_F2;
      end
      S_F2: begin
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = off_q;
        mem_o.wr_data = '{is_free: 1'b1, size: hsize_q, no_link: nl_q, link: link_q};
        if (nl_q) begin
          state_d = S_F6;
        end else begin
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = link_q;
          state_d = S_F3;
        end
      end
      // previous tail: merge left when free
      S_F3: begin
        if (!rdata_i.is_free) begin
          state_d = S_F6;
        end else begin
          calc_o = '{a: {1'b0, link_q}, b: {1'b0, rdata_i.size}, k: K_TAG, sub: 1'b1};
          off_d  = sum_i[AW-1:0];
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = sum_i[AW-1:0];
          state_d = S_F4;
        end
      end
      S_F4: begin
        calc_o  = '{a: {1'b0, rdata_i.size}, b: {1'b0, hsize_q}, k: K_PAIR, sub: 1'b0};
        hsize_d = sum_i[AW-1:0];
        nl_d    = rdata_i.no_link;
        link_d  = rdata_i.link;
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = off_q;
        mem_o.wr_data = '{is_free: 1'b1, size: sum_i[AW-1:0], no_link: rdata_i.no_link,
                          link: rdata_i.link};
        state_d = S_F5;
      end
      S_F5: begin
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = end_q;
        mem_o.wr_data = '{is_free: 1'b1, size: hsize_q, no_link: endnl_q, link: endlink_q};
        state_d = S_F6;
      end
      S_F6: begin
        ok_d = 1'b1;
        if (endnl_q) begin
          state_d = S_DONE;
        end else begin
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = endlink_q;
          state_d = S_F7;
        end
      end
      // next head: merge right when free
      S_F7: begin
        if (!rdata_i.is_free) begin
          state_d = S_DONE;
        end else begin
          calc_o  = '{a: {1'b0, endlink_q}, b: {1'b0, rdata_i.size}, k: K_TAG, sub: 1'b0};
          end_d   = sum_i[AW-1:0];
          tsize_d = rdata_i.size;
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = sum_i[AW-1:0];
          state_d = S_F8;
        end
      end
      S_F8: begin
        endnl_d   = rdata_i.no_link;
        endlink_d = rdata_i.link;
        calc_o  = '{a: {1'b0, hsize_q}, b: {1'b0, tsize_q}, k: K_PAIR, sub: 1'b0};
        hsize_d = sum_i[AW-1:0];
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = off_q;
        mem_o.wr_data = '{is_free: 1'b1, size: sum_i[AW-1:0], no_link: nl_q, link: link_q};
        state_d = S_F9;
      end
      S_F9: begin
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = end_q;
        mem_o.wr_data = '{is_free: 1'b1, size: hsize_q, no_link: endnl_q, link: endlink_q};
        state_d = S_DONE;
      end
      // present the result word
      S_DONE: begin
        done_d   = 1'b1;
        status_d = !ok_q;
        ra_d     = (op_q == OP_ALLOC && ok_q) ? raddr_q : '0;
        if (op_q == OP_REPORT) begin
          lc_d = count_q;
          ub_d = used_q;
          lf_d = big_q;
        end else begin
          lc_d = '0;
          ub_d = '0;
          lf_d = '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT0;
      end
    endcase

    // take a new arena size and rebuild
    if (arena_size_we_i) begin
      asize_d = asize_sat;
      state_d = S_INIT0;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign result_address_o = ra_q;
  assign live_count_o     = lc_q;
  assign used_bytes_o     = ub_q;
  assign largest_free_o   = lf_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !arena_size_we_i) |=> busy)
    else $error("accepted word did not start work");

  a_walk_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_W_HD || state_q == S_W_TD) |-> !mem_o.wr_en)
    else $error("tag write during chain walk");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held");

endmodule

// ===== rtl/boundary_tag_allocator_unit.sv =====
`timescale 1ns / 1ps
// Boundary-tag first-fit allocator over an arena of up to 4096 bytes.
// Commands: raise start with opcode_i, request_size_i and block_address_i;
// the word is taken at a clock edge where start is high, busy is low and
// arena_size_we_i is low. busy stays high until the command is finished.
// One result word follows each command: done_o is high for exactly one cycle
// together with status_o, result_address_o, live_count_o, used_bytes_o,
// largest_free_o. The receiver cannot stall; it must take the word then.
// Sequence: the block chain is walked through one tag store port, with a
// head read and a tail read per block visited. On a hit, an allocation
// reads the block's tail, sizes the free remainder, writes the remainder's
// head and tail, then the allocated head and tail; a free marks the tail and
// head free, merges a free left neighbor, then a free right neighbor. The
// S_DONE state formats the result and done_o follows in the next cycle; an
// unused opcode goes straight to S_DONE. busy is low in the done_o cycle,
// so the next command can be taken there with no further gap.
// Reset and every write of arena_size_i (arena_size_we_i high; the user
// must write it with no command in flight, which the block does not enforce)
// rebuild the arena as one free block, head then tail, with busy high; the
// counters clear. Only live tags are ever read, so no memory sweep is run.
module boundary_tag_allocator_unit import bta_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          arena_size_we_i,
  input  logic [12:0]   arena_size_i,
  input  logic [1:0]    opcode_i,
  input  logic [11:0]   request_size_i,
  input  logic [11:0]   block_address_i,
  output logic          done_o,
  output logic          status_o,
  output logic [11:0]   result_address_o,
  output logic [8:0]    live_count_o,
  output logic [11:0]   used_bytes_o,
  output logic [11:0]   largest_free_o
);

  mem_req_t      mem_req;
  tag_t          rdata;
  calc_req_t     calc_req;
  logic [SW-1:0] sum;

  bta_calc u_calc (
    .req_i (calc_req),
    .sum_o (sum)
  );

  bta_tag_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bta_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .arena_size_we_i  (arena_size_we_i),
    .arena_size_i     (arena_size_i),
    .opcode_i         (opcode_i),
    .request_size_i   (request_size_i),
    .block_address_i  (block_address_i),
    .mem_o            (mem_req),
    .rdata_i          (rdata),
    .calc_o           (calc_req),
    .sum_i            (sum),
    .done_o           (done_o),
    .status_o         (status_o),
    .result_address_o (result_address_o),
    .live_count_o     (live_count_o),
    .used_bytes_o     (used_bytes_o),
    .largest_free_o   (largest_free_o)
  );

endmodule
